/* sv/rnsas_pkg.sv */
// Package for the radix-N digit-serial adder/subtractor.
// Holds transaction payload types, operation codes, radix limits and ASCII digit helpers.
// No dependencies.
package rnsas_pkg;

  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned VALUE_W     = 6;
  localparam int unsigned SUM_W       = 7;
  localparam int unsigned CHAR_W      = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [7:0]         ASCII_ZERO  = 8'h30;
  localparam logic [7:0]         ASCII_NINE  = 8'h39;
  localparam logic [7:0]         ASCII_A     = 8'h41;
  localparam logic [7:0]         ASCII_Z     = 8'h5A;
  localparam logic [VALUE_W-1:0] DEC_BASE    = 6'd10;
  localparam logic [VALUE_W-1:0] NO_DIGIT    = 6'd63;
  localparam logic [CHAR_W-1:0]  CHAR_ONE    = 7'h31;

  typedef enum logic {
    KIND_ADD = 1'b0,
    KIND_SUB = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] digit_a;
    logic [7:0] digit_b;
    logic       last_pair;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] result_char;
    logic              result_last;
    logic              bad_digit;
  } out_item_t;

  // Non-digits map to a value no radix accepts.
  function automatic logic [VALUE_W-1:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
        d = c - ASCII_ZERO;
      end else if (c >= ASCII_A && c <= ASCII_Z) begin
        d = c - ASCII_A + {2'b00, DEC_BASE};
      end else begin
        d = {2'b00, NO_DIGIT};
      end
      digit_value = d[VALUE_W-1:0];
    end
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [VALUE_W-1:0] v);
    logic [7:0] c;
    begin
      if (v < DEC_BASE) begin
        c = ASCII_ZERO + {2'b00, v};
      end else begin
        c = ASCII_A + {2'b00, v} - {2'b00, DEC_BASE};
      end
      digit_char = c[CHAR_W-1:0];
    end
  endfunction

endpackage

/* sv/rnsas_if.sv */
// Valid/ready channel interfaces for digit pairs and result digits.
// Depends on rnsas_pkg for the payload types.
interface rnsas_in_if;
  import rnsas_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rnsas_out_if;
  import rnsas_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/radix_n_serial_add_subtract_top.sv */
// Radix-N digit-serial adder/subtractor, top level.
// Depends on rnsas_pkg and the channel interfaces in rnsas_if.sv.
// Result: each digit is registered in the output register when its pair is accepted.
// Throughput: one digit pair per cycle unless digits.ready stalls the output; a pair
//   ending an addition with a carry blocks input while the output register emits its extra '1'.
// Reset (rst, synchronous): radix 10, carry clear, output and extra slot empty.
module radix_n_serial_add_subtract_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                radix_we,
  input  logic [rnsas_pkg::RADIX_W-1:0]       radix_wdata,
  rnsas_in_if.sink                            pairs,
  rnsas_out_if.source                         digits
);
  import rnsas_pkg::*;

  logic [RADIX_W-1:0] radix;
  logic               carry_bit;
  logic               carry_next;
  logic               out_valid;
  out_item_t          out_item;
  logic               extra_pending;
  logic               extra_bad;

  logic [RADIX_W-1:0] r_eff;
  logic [VALUE_W-1:0] a_raw, b_raw, a_val, b_val, digit;
  logic               a_bad, b_bad, bad;
  logic [SUM_W-1:0]   sum, sub, wrap;
  logic               cout;
  logic               extra;
  logic               accept;
  logic               drain;

  always_comb begin
    priority if (radix < RADIX_MIN) begin
      r_eff = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      r_eff = RADIX_MAX;
    end else begin
      r_eff = radix;
    end
  end

  always_comb begin
    a_raw = digit_value(pairs.data.digit_a);
    b_raw = digit_value(pairs.data.digit_b);
    a_bad = a_raw >= r_eff;
    b_bad = b_raw >= r_eff;
    bad   = a_bad | b_bad;
    a_val = a_bad ? '0 : a_raw;
    b_val = b_bad ? '0 : b_raw;
    sum   = {1'b0, a_val} + {1'b0, b_val} + {{(SUM_W-1){1'b0}}, carry_bit};
    sub   = {1'b0, b_val} + {{(SUM_W-1){1'b0}}, carry_bit};
    wrap  = {1'b0, a_val} + {1'b0, r_eff} - sub;
    unique case (pairs.data.kind)
      KIND_ADD: begin
        if (sum >= {1'b0, r_eff}) begin
          digit = sum[VALUE_W-1:0] - r_eff;
          cout  = 1'b1;
        end else begin
          digit = sum[VALUE_W-1:0];
          cout  = 1'b0;
        end
      end
      KIND_SUB: begin
        if ({1'b0, a_val} >= sub) begin
          digit = a_val - sub[VALUE_W-1:0];
          cout  = 1'b0;
        end else begin
          digit = wrap[VALUE_W-1:0];
          cout  = 1'b1;
        end
      end
      default: begin
        digit = '0;
        cout  = 1'b0;
      end
    endcase
    extra      = (pairs.data.kind == KIND_ADD) && pairs.data.last_pair && cout;
    carry_next = pairs.data.last_pair ? 1'b0 : cout;
  end

  assign drain        = out_valid & digits.ready;
  assign pairs.ready  = ~extra_pending & (~out_valid | digits.ready);
  assign accept       = pairs.valid & pairs.ready;
  assign digits.valid = out_valid;
  assign digits.data  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (radix_we) begin
      radix <= radix_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_bit     <= 1'b0;
      out_valid     <= 1'b0;
      extra_pending <= 1'b0;
    end else begin
      if (accept) begin
        carry_bit     <= carry_next;
        out_valid     <= 1'b1;
        extra_pending <= extra;
      end else if (drain) begin
        out_valid     <= extra_pending;
        extra_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item.result_char <= digit_char(digit);
      out_item.result_last <= pairs.data.last_pair & ~extra;
      out_item.bad_digit   <= bad;
      extra_bad            <= bad;
    end else if (drain && extra_pending) begin
      out_item.result_char <= CHAR_ONE;
      out_item.result_last <= 1'b1;
      out_item.bad_digit   <= extra_bad;
    end
  end

endmodule
